@@ sv/rhh_pkg.sv @@
// ----------------------------------------------------------------------------
// rhh_pkg
// Shared types and constants for the Robin Hood hash table.
// ----------------------------------------------------------------------------
package rhh_pkg;

    localparam int TABLE_SIZE_DEF = 1024;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int FIELD_W = 32;
    localparam int COUNT_W = 11;

    localparam logic FUNC_SET = 1'b0;
    localparam logic FUNC_GET = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_HOLD
    } state_t;

endpackage

@@ sv/robin_hood_hash_table.sv @@
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// Robin Hood open-addressing hash table with linear probing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): one transfer carries func (0 = set,
//   1 = get), key, hash and value. The low bits of hash pick the home slot.
//   Result channel (m_valid/m_ready): one transfer per item with status
//   (ok, miss, full), read_value (zero unless a get hits) and entry_count.
//   Sequence: the home slot read is launched as the item is accepted, the
//   slots are then probed in turn and the result is handed over. A set on
//   a completely full table first walks the whole path without writing
//   (TABLE_SIZE probes at most); if it ends at the key's slot it repeats it
//   committing, else it returns full. Throughput is set by the slot RAM's
//   one read and one write port: one slot per cycle, one item at a time.
//   Reset: the slot RAM is swept to empty, one slot per cycle;
//   s_ready stays low meanwhile.
//   Stall: a finished result waits in the output register while the next
//   item is accepted and probed; a second result waits until m_ready.
// ----------------------------------------------------------------------------
module robin_hood_hash_table #(
    parameter int TABLE_SIZE = rhh_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BITS   = rhh_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = rhh_pkg::VALUE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [rhh_pkg::FIELD_W-1:0] s_key,
    input  logic [rhh_pkg::FIELD_W-1:0] s_hash,
    input  logic [rhh_pkg::FIELD_W-1:0] s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [rhh_pkg::FIELD_W-1:0] m_read_value,
    output logic [rhh_pkg::COUNT_W-1:0] m_entry_count
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int PL_W  = $clog2(TABLE_SIZE + 1);
    localparam int ENT_W = PL_W + KEY_BITS + VALUE_BITS;

    // State and control
    rhh_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [PL_W-1:0]  count_reg, count_next;
    logic             m_valid_reg, m_valid_next;

    // Item context
    logic                  func_reg, func_next;
    logic                  dry_reg, dry_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [IDX_W-1:0]      home_reg, home_next;
    logic [KEY_BITS-1:0]   ck_reg, ck_next;
    logic [VALUE_BITS-1:0] cv_reg, cv_next;
    logic [PL_W-1:0]       cp_reg, cp_next;
    logic [IDX_W-1:0]      addr_reg, addr_next;
    logic [PL_W-1:0]       step_reg, step_next;

    // Pending and output results
    rhh_pkg::status_t      pst_reg, pst_next;
    logic [VALUE_BITS-1:0] pval_reg, pval_next;
    rhh_pkg::status_t      ost_reg, ost_next;
    logic [rhh_pkg::FIELD_W-1:0] oval_reg, oval_next;
    logic [rhh_pkg::COUNT_W-1:0] ocnt_reg, ocnt_next;

    // RAM port
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;

    logic [PL_W-1:0]       sp;
    logic [KEY_BITS-1:0]   sk;
    logic [VALUE_BITS-1:0] sv;
    logic                  out_free;
    logic                  last_step;

    assign sp = rd_data[ENT_W-1 -: PL_W];
    assign sk = rd_data[VALUE_BITS +: KEY_BITS];
    assign sv = rd_data[VALUE_BITS-1:0];

    assign out_free  = !m_valid_reg || m_ready;
    assign last_step = (step_reg == PL_W'(TABLE_SIZE - 1));

    assign s_ready       = (state_reg == rhh_pkg::S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = ost_reg;
    assign m_read_value  = oval_reg;
    assign m_entry_count = ocnt_reg;

    rhh_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_SIZE)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rhh_pkg::S_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        dry_reg  <= dry_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
        home_reg <= home_next;
        ck_reg   <= ck_next;
        cv_reg   <= cv_next;
        cp_reg   <= cp_next;
        addr_reg <= addr_next;
        step_reg <= step_next;
        pst_reg  <= pst_next;
        pval_reg <= pval_next;
        ost_reg  <= ost_next;
        oval_reg <= oval_next;
        ocnt_reg <= ocnt_next;
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        func_next    = func_reg;
        dry_next     = dry_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        home_next    = home_reg;
        ck_next      = ck_reg;
        cv_next      = cv_reg;
        cp_next      = cp_reg;
        addr_next    = addr_reg;
        step_next    = step_reg;
        pst_next     = pst_reg;
        pval_next    = pval_reg;
        ost_next     = ost_reg;
        oval_next    = oval_reg;
        ocnt_next    = ocnt_reg;
        wr_en        = 1'b0;
        wr_addr      = addr_reg;
        wr_data      = {cp_reg, ck_reg, cv_reg};
        rd_addr      = addr_reg + IDX_W'(1);

        // Drop the output once it is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            rhh_pkg::S_CLEAR: begin
                // Sweep every slot to empty
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(TABLE_SIZE - 1)) begin
                    state_next = rhh_pkg::S_IDLE;
                end
            end
            rhh_pkg::S_IDLE: begin
                rd_addr = s_hash[IDX_W-1:0];
                if (s_valid) begin
                    func_next  = s_func;
                    // A set on a full table walks once without writing
                    dry_next   = (s_func == rhh_pkg::FUNC_SET) &&
                                 (count_reg == PL_W'(TABLE_SIZE));
                    key_next   = KEY_BITS'(s_key);
                    val_next   = VALUE_BITS'(s_value);
                    home_next  = s_hash[IDX_W-1:0];
                    ck_next    = KEY_BITS'(s_key);
                    cv_next    = VALUE_BITS'(s_value);
                    cp_next    = PL_W'(1);
                    addr_next  = s_hash[IDX_W-1:0];
                    step_next  = '0;
                    state_next = rhh_pkg::S_PROBE;
                end
            end
            rhh_pkg::S_PROBE: begin
                addr_next = addr_reg + IDX_W'(1);
                step_next = step_reg + PL_W'(1);
                pval_next = '0;
                if (func_reg == rhh_pkg::FUNC_GET) begin
                    if (sp == '0 || sp < cp_reg) begin
                        pst_next   = rhh_pkg::ST_MISS;
                        state_next = rhh_pkg::S_HOLD;
                    end else if (sk == key_reg) begin
                        pst_next   = rhh_pkg::ST_OK;
                        pval_next  = sv;
                        state_next = rhh_pkg::S_HOLD;
                    end else if (last_step) begin
                        pst_next   = rhh_pkg::ST_MISS;
                        state_next = rhh_pkg::S_HOLD;
                    end else begin
                        cp_next = cp_reg + PL_W'(1);
                    end
                end else begin
                    if (sp == '0 || sk == ck_reg) begin
                        if (dry_reg) begin
                            // Path ends in a slot: rerun it and commit
                            dry_next  = 1'b0;
                            ck_next   = key_reg;
                            cv_next   = val_reg;
                            cp_next   = PL_W'(1);
                            addr_next = home_reg;
                            step_next = '0;
                            rd_addr   = home_reg;
                        end else begin
                            wr_en = 1'b1;
                            if (sp == '0) begin
                                count_next = count_reg + PL_W'(1);
                            end
                            pst_next   = rhh_pkg::ST_OK;
                            state_next = rhh_pkg::S_HOLD;
                        end
                    end else begin
                        if (sp < cp_reg) begin
                            // Swap the carried entry with the richer one
                            wr_en   = !dry_reg;
                            ck_next = sk;
                            cv_next = sv;
                            cp_next = sp + PL_W'(1);
                        end else begin
                            cp_next = cp_reg + PL_W'(1);
                        end
                        if (last_step) begin
                            wr_en      = 1'b0;
                            pst_next   = rhh_pkg::ST_FULL;
                            state_next = rhh_pkg::S_HOLD;
                        end
                    end
                end
            end
            rhh_pkg::S_HOLD: begin
                // Advance the result into the output register when free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    ost_next     = pst_reg;
                    oval_next    = rhh_pkg::FIELD_W'(pval_reg);
                    ocnt_next    = rhh_pkg::COUNT_W'(count_reg);
                    state_next   = rhh_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rhh_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/rhh_ram.sv @@
// ----------------------------------------------------------------------------
// rhh_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rhh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
